// ----- design/swm_pkg.sv -----
`default_nettype none

package swm_pkg;

  localparam int MAX_WINDOW_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int CFG_W            = 7;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_AGE,
    OP_COMPACT,
    OP_INSERT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     take_right;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMPACT,
    ST_INSERT,
    ST_SELECT,
    ST_EMIT
  } state_t;

  function automatic int age_width(input int depth);
    age_width = (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

`default_nettype wire

// ----- design/swm_in_if.sv -----
`default_nettype none

interface swm_in_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ----- design/swm_out_if.sv -----
`default_nettype none

interface swm_out_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [SAMPLE_WIDTH:0] median_twice;

  modport source (output valid, output median_twice, input ready);
  modport sink (input valid, input median_twice, output ready);
endinterface

`default_nettype wire

// ----- design/swm_cell.sv -----
`default_nettype none

module swm_cell #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int AGE_W        = 6
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  swm_pkg::cell_ctl_t             ctl,
  input  logic signed [SAMPLE_WIDTH-1:0] x,
  input  logic        [AGE_W-1:0]        lenm1,
  input  logic signed [SAMPLE_WIDTH-1:0] left_val,
  input  logic        [AGE_W-1:0]        left_age,
  input  logic                           left_v,
  input  logic                           left_gt,
  input  logic signed [SAMPLE_WIDTH-1:0] right_val,
  input  logic        [AGE_W-1:0]        right_age,
  input  logic                           right_v,
  output logic signed [SAMPLE_WIDTH-1:0] val,
  output logic        [AGE_W-1:0]        age,
  output logic                           v,
  output logic                           gt
);
  import swm_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] val_r, val_nxt;
  logic        [AGE_W-1:0]        age_r, age_nxt;
  logic                           v_r, v_nxt;

  assign gt  = v_r && (val_r > x);
  assign val = val_r;
  assign age = age_r;
  assign v   = v_r;

  always_comb begin
    val_nxt = val_r;
    age_nxt = age_r;
    v_nxt   = v_r;
    unique case (ctl.op)
      OP_HOLD: begin
      end
      OP_AGE: begin
        // entries too old for the window leave, the rest grow older
        if (v_r) begin
          if (age_r >= lenm1) begin
            v_nxt = 1'b0;
          end else begin
            age_nxt = age_r + 1'b1;
          end
        end
      end
      OP_COMPACT: begin
        if (ctl.take_right) begin
          val_nxt = right_val;
          age_nxt = right_age;
          v_nxt   = right_v;
        end
      end
      OP_INSERT: begin
        if (left_gt) begin
          val_nxt = left_val;
          age_nxt = left_age;
          v_nxt   = 1'b1;
        end else if ((!v_r || gt) && left_v) begin
          val_nxt = x;
          age_nxt = '0;
          v_nxt   = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    age_r <= age_nxt;
  end

endmodule

`default_nettype wire

// ----- design/sliding_window_median.sv -----
// sequence: a request is taken in ST_IDLE, where the cells age; in ST_COMPACT the cell row
//   closes one hole per cycle below the highest kept entry (0 or 1 holes in steady state, up to
//   MAX_WINDOW - 1 after the window length shrinks); then come ST_INSERT, ST_SELECT and ST_EMIT,
//   which waits while a result finds the output register full; requests are taken only in ST_IDLE
// overlap: a finished result waits in the output register while the next request is taken
// reset: synchronous active-low rst_n empties the window and sets window_length to 1
`default_nettype none

module sliding_window_median #(
  parameter int MAX_WINDOW   = swm_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  swm_in_if.sink                    in_chan,
  swm_out_if.source                 out_chan,
  input  logic                      cfg_wr_en,
  input  logic [swm_pkg::CFG_W-1:0] cfg_wr_data
);
  import swm_pkg::*;

  localparam int N  = MAX_WINDOW;
  localparam int AW = age_width(MAX_WINDOW);
  localparam int LW = (CFG_W > AW + 1) ? CFG_W : AW + 1;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] wlen_r;
  logic [LW-1:0]    wlen_ext;
  logic [LW-1:0]    eff_len;
  logic [AW-1:0]    lenm1;
  logic [AW:0]      lenm1_inc;
  logic [AW-1:0]    lo_idx;
  logic [AW-1:0]    hi_idx;

  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic signed [SAMPLE_WIDTH-1:0] lo_r, hi_r;
  logic                           res_r;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH:0]   out_data_r;

  logic signed [SAMPLE_WIDTH-1:0] val_a [N];
  logic        [AW-1:0]           age_a [N];
  logic        [N-1:0]            v_a;
  logic        [N-1:0]            gt_a;
  logic        [N-1:0]            right_v_a;
  logic        [N-1:0]            hole_pre;
  logic                           bubble;
  logic                           accept;
  logic                           load_out;
  cell_op_t                       op;

  // window length clamped to 1..MAX_WINDOW
  always_comb begin
    wlen_ext = LW'(wlen_r);
    if (wlen_ext == '0) begin
      eff_len = LW'(1);
    end else if (wlen_ext > LW'(MAX_WINDOW)) begin
      eff_len = LW'(MAX_WINDOW);
    end else begin
      eff_len = wlen_ext;
    end
  end

  assign lenm1     = AW'(eff_len - LW'(1));
  assign lenm1_inc = {1'b0, lenm1} + 1'b1;
  assign lo_idx    = lenm1 >> 1;
  assign hi_idx    = AW'(lenm1_inc >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= CFG_W'(1);
    end else if (cfg_wr_en) begin
      wlen_r <= cfg_wr_data;
    end
  end

  // lowest hole and everything above it moves down one cell
  always_comb begin
    hole_pre = ~v_a;
    for (int s = 1; s < N; s = s * 2) begin
      hole_pre = hole_pre | (hole_pre << s);
    end
  end

  assign bubble = |(~v_a & right_v_a);

  assign accept       = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    op        = OP_HOLD;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op        = OP_AGE;
          state_nxt = ST_COMPACT;
        end
      end
      ST_COMPACT: begin
        if (bubble) begin
          op = OP_COMPACT;
        end else begin
          state_nxt = ST_INSERT;
        end
      end
      ST_INSERT: begin
        op        = OP_INSERT;
        state_nxt = ST_SELECT;
      end
      ST_SELECT: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!res_r) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_chan.ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      logic signed [SAMPLE_WIDTH-1:0] l_val, r_val;
      logic        [AW-1:0]           l_age, r_age;
      logic                           l_v, l_gt, r_v;
      cell_ctl_t                      ctl;

      if (gi == 0) begin : g_first
        assign l_val = '0;
        assign l_age = '0;
        assign l_v   = 1'b1;
        assign l_gt  = 1'b0;
      end else begin : g_mid_l
        assign l_val = val_a[gi-1];
        assign l_age = age_a[gi-1];
        assign l_v   = v_a[gi-1];
        assign l_gt  = gt_a[gi-1];
      end

      if (gi == N - 1) begin : g_last
        assign r_val = '0;
        assign r_age = '0;
        assign r_v   = 1'b0;
      end else begin : g_mid_r
        assign r_val = val_a[gi+1];
        assign r_age = age_a[gi+1];
        assign r_v   = v_a[gi+1];
      end

      assign right_v_a[gi]  = r_v;
      assign ctl.op         = op;
      assign ctl.take_right = hole_pre[gi];

      swm_cell #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .AGE_W        (AW)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .x         (x_r),
        .lenm1     (lenm1),
        .left_val  (l_val),
        .left_age  (l_age),
        .left_v    (l_v),
        .left_gt   (l_gt),
        .right_val (r_val),
        .right_age (r_age),
        .right_v   (r_v),
        .val       (val_a[gi]),
        .age       (age_a[gi]),
        .v         (v_a[gi]),
        .gt        (gt_a[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r <= in_chan.sample;
    end
    if (state_r == ST_SELECT) begin
      lo_r <= val_a[lo_idx];
      hi_r <= val_a[hi_idx];
    end
    if (load_out) begin
      out_data_r <= {lo_r[SAMPLE_WIDTH-1], lo_r} + {hi_r[SAMPLE_WIDTH-1], hi_r};
    end
  end

  // a result exists once the window holds exactly len entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= 1'b0;
    end else if (state_r == ST_SELECT) begin
      res_r <= v_a[lenm1];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_chan.ready;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.median_twice = out_data_r;

endmodule

`default_nettype wire
